>>> rtl/gibs_pkg.sv
package gibs_pkg;

    // kept-box list depth and counter widths
    localparam int CELLS      = 256;
    localparam int SLOT_W     = $clog2(CELLS);
    localparam int CNT_W      = $clog2(CELLS + 1);
    localparam int IDX_W      = 13;

    // coordinate and area arithmetic
    localparam int COORD_W    = 16;
    localparam int EXT_W      = COORD_W + 1;
    localparam int AREA_W     = 2 * EXT_W;
    localparam int UNI_W      = AREA_W + 1;
    localparam int THR_W      = 16;
    localparam int IOU_SHIFT  = 15;
    localparam int PROD_W     = THR_W + UNI_W;
    localparam int PIXEL_ONE  = 16;

    // compare pipeline depth, head of ring to compare result
    localparam int IOU_LAT    = 5;
    localparam int DRAIN_W    = $clog2(IOU_LAT);

    // configuration register indexes and reset values
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_MAX_KEEP  = 1'b1;
    localparam logic [THR_W-1:0] THR_RESET  = 16'd22938;
    localparam logic [CNT_W-1:0] KEEP_RESET = CNT_W'(CELLS);

    typedef struct packed {
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] x2;
        logic [COORD_W-1:0] y2;
    } t_box;

    typedef struct packed {
        logic valid;
        logic over;
    } t_iou_res;

endpackage

>>> rtl/gibs_cell.sv
module gibs_cell
    import gibs_pkg::*;
(
    input  logic i_clk,
    input  logic i_shift,
    input  logic i_load,
    input  t_box i_prev,
    input  t_box i_new,
    output t_box o_box
);

    t_box r_box;

    // one slot of the ring: load a new kept box or take the neighbor's
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_box <= i_new;
        end else if (i_shift) begin
            r_box <= i_prev;
        end
    end

    assign o_box = r_box;

endmodule

>>> rtl/gibs_iou.sv
module gibs_iou
    import gibs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_box             i_cand,
    input  t_box             i_kept,
    input  logic [THR_W-1:0] i_thr,
    output t_iou_res         o_res
);

    // inclusive extent, clamped at zero
    function automatic logic [EXT_W-1:0] f_extent(input logic [COORD_W-1:0] lo,
                                                  input logic [COORD_W-1:0] hi);
        logic [EXT_W-1:0] top;
        logic [EXT_W-1:0] lo_w;
        top  = {1'b0, hi} + EXT_W'(PIXEL_ONE);
        lo_w = {1'b0, lo};
        return (top > lo_w) ? (top - lo_w) : '0;
    endfunction

    logic [COORD_W-1:0] w_ix1, w_iy1, w_ix2, w_iy2;

    logic               r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [EXT_W-1:0]   r_iw, r_ih, r_aw, r_ah, r_bw, r_bh;
    logic [AREA_W-1:0]  r_inter2, r_sa, r_sb;
    logic [AREA_W-1:0]  r_inter3;
    logic [UNI_W-1:0]   r_uni;
    logic [PROD_W-1:0]  r_lhs, r_rhs;
    logic               r_over;

    // intersection corners
    assign w_ix1 = (i_cand.x1 > i_kept.x1) ? i_cand.x1 : i_kept.x1;
    assign w_iy1 = (i_cand.y1 > i_kept.y1) ? i_cand.y1 : i_kept.y1;
    assign w_ix2 = (i_cand.x2 < i_kept.x2) ? i_cand.x2 : i_kept.x2;
    assign w_iy2 = (i_cand.y2 < i_kept.y2) ? i_cand.y2 : i_kept.y2;

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1: extents
    always_ff @(posedge i_clk) begin
        r_iw <= f_extent(w_ix1, w_ix2);
        r_ih <= f_extent(w_iy1, w_iy2);
        r_aw <= f_extent(i_cand.x1, i_cand.x2);
        r_ah <= f_extent(i_cand.y1, i_cand.y2);
        r_bw <= f_extent(i_kept.x1, i_kept.x2);
        r_bh <= f_extent(i_kept.y1, i_kept.y2);
    end

    // stage 2: areas
    always_ff @(posedge i_clk) begin
        r_inter2 <= AREA_W'(r_iw) * AREA_W'(r_ih);
        r_sa     <= AREA_W'(r_aw) * AREA_W'(r_ah);
        r_sb     <= AREA_W'(r_bw) * AREA_W'(r_bh);
    end

    // stage 3: union, intersection never exceeds either area
    always_ff @(posedge i_clk) begin
        r_uni    <= UNI_W'(r_sa) + UNI_W'(r_sb) - UNI_W'(r_inter2);
        r_inter3 <= r_inter2;
    end

    // stage 4: scale intersection, threshold times union
    always_ff @(posedge i_clk) begin
        r_lhs <= PROD_W'(r_inter3) << IOU_SHIFT;
        r_rhs <= PROD_W'(i_thr) * PROD_W'(r_uni);
    end

    // stage 5: suppress when iou exceeds the threshold
    always_ff @(posedge i_clk) begin
        r_over <= (r_lhs > r_rhs);
    end

    assign o_res.valid = r_v5;
    assign o_res.over  = r_over;

endmodule

>>> rtl/greedy_iou_box_suppression_core.sv
// an accepted item skips the compare walk when the list is empty or at the
//   max_keep limit; otherwise after a 256-step rotation of the kept-box ring,
//   one kept box into the iou compare pipeline per cycle, then a pipeline drain
// one item at a time, accepted only while idle, also while a result waits
// reset: synchronous active low; clears counters, control and registers to
//   threshold 22938 and max_keep 256; kept-box slots are not cleared
module greedy_iou_box_suppression_core
    import gibs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [THR_W-1:0]   i_cfg_data,
    // input items
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_box_x1,
    input  logic [COORD_W-1:0] i_box_y1,
    input  logic [COORD_W-1:0] i_box_x2,
    input  logic [COORD_W-1:0] i_box_y2,
    input  logic               i_is_last,
    // result items
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_keep,
    output logic [IDX_W-1:0]   o_box_index,
    output logic [CNT_W-1:0]   o_kept_count,
    output logic               o_set_done
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]         r_state;
    logic [THR_W-1:0]   r_thr;
    logic [CNT_W-1:0]   r_max_keep;
    logic [CNT_W-1:0]   r_kept_total;
    logic [IDX_W-1:0]   r_item_cnt;
    logic [SLOT_W-1:0]  r_step;
    logic [DRAIN_W-1:0] r_drain;
    logic               r_below;
    logic               r_supp;
    t_box               r_cand;
    logic               r_last;

    logic               r_out_valid;
    logic               r_out_keep;
    logic [IDX_W-1:0]   r_out_index;
    logic [CNT_W-1:0]   r_out_count;
    logic               r_out_done;

    logic [CNT_W-1:0]   w_limit;
    logic               w_accept;
    logic               w_out_free;
    logic               w_commit;
    logic               w_keep;
    logic [CNT_W-1:0]   w_new_total;
    logic               w_shift;
    logic               w_feed;
    t_box               w_in_box;
    t_box               w_ring [CELLS];
    logic [CELLS-1:0]   w_load;
    t_iou_res           w_res;

    assign w_limit    = (r_max_keep > CNT_W'(CELLS)) ? CNT_W'(CELLS) : r_max_keep;
    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_commit   = (r_state == ST_DONE) && w_out_free;
    assign w_keep     = r_below && !r_supp;
    assign w_new_total = w_keep ? (r_kept_total + CNT_W'(1)) : r_kept_total;
    assign w_shift    = (r_state == ST_WALK);
    assign w_feed     = w_shift && ({1'b0, r_step} < r_kept_total);

    assign w_in_box.x1 = i_box_x1;
    assign w_in_box.y1 = i_box_y1;
    assign w_in_box.x2 = i_box_x2;
    assign w_in_box.y2 = i_box_y2;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= THR_RESET;
            r_max_keep <= KEEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_thr      <= i_cfg_data;
                CFG_MAX_KEEP:  r_max_keep <= i_cfg_data[CNT_W-1:0];
                default:       r_thr      <= r_thr;
            endcase
        end
    end

    // ring of kept boxes, slot 0 is the head
    always_comb begin
        for (int k = 0; k < CELLS; k++) begin
            w_load[k] = w_commit && w_keep && (r_kept_total[SLOT_W-1:0] == SLOT_W'(k));
        end
    end

    for (genvar g = 0; g < CELLS; g++) begin : g_ring
        gibs_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_load  (w_load[g]),
            .i_prev  (w_ring[(g + 1) % CELLS]),
            .i_new   (r_cand),
            .o_box   (w_ring[g])
        );
    end

    // iou compare pipeline against the head slot
    gibs_iou u_iou (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_feed),
        .i_cand  (r_cand),
        .i_kept  (w_ring[0]),
        .i_thr   (r_thr),
        .o_res   (w_res)
    );

    // candidate capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cand <= w_in_box;
            r_last <= i_is_last;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_kept_total <= '0;
            r_item_cnt   <= '0;
            r_step       <= '0;
            r_drain      <= '0;
            r_below      <= 1'b0;
            r_supp       <= 1'b0;
        end else begin
            if (w_res.valid && w_res.over) begin
                r_supp <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_below <= (r_kept_total < w_limit);
                        r_supp  <= 1'b0;
                        r_step  <= '0;
                        r_drain <= '0;
                        if ((r_kept_total < w_limit) && (r_kept_total != '0)) begin
                            r_state <= ST_WALK;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_WALK: begin
                    r_step <= r_step + SLOT_W'(1);
                    if (r_step == SLOT_W'(CELLS - 1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_drain <= r_drain + DRAIN_W'(1);
                    if (r_drain == DRAIN_W'(IOU_LAT - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                        if (r_last) begin
                            r_kept_total <= '0;
                            r_item_cnt   <= '0;
                        end else begin
                            r_kept_total <= w_new_total;
                            r_item_cnt   <= r_item_cnt + IDX_W'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_keep  <= w_keep;
            r_out_index <= r_item_cnt;
            r_out_count <= w_new_total;
            r_out_done  <= r_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_keep       = r_out_keep;
    assign o_box_index  = r_out_index;
    assign o_kept_count = r_out_count;
    assign o_set_done   = r_out_done;

    // kept count never passes the list depth
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept_total <= CNT_W'(CELLS))
        else $error("kept total above list depth");

    // compare results only arrive while walking or draining
    a_res_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> (r_state == ST_WALK || r_state == ST_DRAIN))
        else $error("compare result outside walk");

    // a kept box always counts itself
    a_keep_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_keep) |-> (o_kept_count != '0))
        else $error("kept box with zero count");

endmodule
